FILE: rtl/cache_tag_replacement_model_assert.svh
// Assertion macros for the checker file of the cache tag store.
// Every property is sampled on the rising clock edge and is switched off
// while reset is held.
`ifndef CACHE_TAG_REPLACEMENT_MODEL_ASSERT_SVH
`define CACHE_TAG_REPLACEMENT_MODEL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CTRM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CTRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ctrm_pkg.sv
// ----------------------------------------------------------------------------
// ctrm_pkg
// Shared widths, register codes and state encoding for the cache tag store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctrm_pkg;

    localparam int ADDR_W  = 31;
    localparam int TAG_W   = 31;
    localparam int CNT_W   = 32;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 4;

    localparam int ASSOC_W  = 2;
    localparam int OFFS_W   = 5;
    localparam int LCL_W    = 4;

    localparam logic [ASSOC_W-1:0] ASSOC_DIRECT = 2'd0;
    localparam logic [ASSOC_W-1:0] ASSOC_SET    = 2'd1;
    localparam logic [ASSOC_W-1:0] ASSOC_FULL   = 2'd2;

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    localparam logic [ASSOC_W-1:0] ASSOC_RST  = ASSOC_DIRECT;
    localparam logic               POLICY_RST = POLICY_FIFO;
    localparam logic [OFFS_W-1:0]  OFFS_RST   = 5'd2;
    localparam logic [LCL_W-1:0]   LCL_RST    = 4'd10;

    typedef enum logic [1:0] {
        REG_ASSOC  = 2'd0,
        REG_POLICY = 2'd1,
        REG_OFFSET = 2'd2,
        REG_LINES  = 2'd3
    } reg_idx_t;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_SETUP  = 7'b0000100,
        S_SCAN   = 7'b0001000,
        S_UPDATE = 7'b0010000,
        S_FILL   = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

endpackage

FILE: rtl/cache_tag_replacement_model.sv
// ----------------------------------------------------------------------------
// cache_tag_replacement_model
// Tag store of a configurable cache with FIFO or LRU replacement and
// saturating access and miss counters.
// ----------------------------------------------------------------------------
// Usage. An item (one word address) is taken at a rising edge where start is
// high and busy is low. The result is shown for exactly one cycle with done
// high; the receiver cannot stall it, so it must take it in that cycle.
// The four configuration registers sit on an APB-style port at byte
// addresses 0, 4, 8 and 12; they are to be written only while the block is
// idle. pready is tied high and reads return the register value.
//
// Timing. One item walks the ways of its set through the single read port of
// the tag store, one line per cycle. A hit under FIFO or direct mapping
// then goes straight to the finish state, a miss that fills a free way
// first writes that way, and an LRU hit or an eviction needs a second
// read-modify-write pass over the set. done is high in the cycle after the
// finish state, with busy already low, so the next item may be offered in
// that cycle and is taken at the edge that ends it. A new item is not taken
// while the last one is still in progress.
//
// Reset. The asynchronous reset loads the register defaults and zeroes both
// counters. After reset the block sweeps the valid bits of all MAX_LINES
// lines, one a cycle, keeping busy high until the sweep ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cache_tag_replacement_model
    import ctrm_pkg::*;
#(
    parameter int MAX_LINES = 1024,
    parameter int SET_WAYS  = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    // item channel
    input  logic               start,
    output logic               busy,
    input  logic [ADDR_W-1:0]  word_address,
    // result channel
    output logic               done,
    output logic               miss,
    output logic               evicted,
    output logic [TAG_W-1:0]   victim_tag,
    output logic [CNT_W-1:0]   access_count,
    output logic [CNT_W-1:0]   miss_count
);

    // Line index width, way counter width and the width of a log2 count.
    localparam int IW = $clog2(MAX_LINES);
    localparam int CW = IW + 1;
    localparam int WL = $clog2(SET_WAYS);
    localparam int LW = $clog2(IW + 1);

    // Configuration registers.
    logic [ASSOC_W-1:0] assoc_reg;
    logic               policy_reg;
    logic [OFFS_W-1:0]  offset_reg;
    logic [LCL_W-1:0]   lines_reg;

    // Geometry derived from the configuration.
    logic [LW-1:0] lcl_eff;
    logic [LW-1:0] ways_log2;
    logic [LW-1:0] sets_log2;
    logic          lru;

    // Sequencer.
    state_t          state_reg, state_next;
    logic [CW-1:0]   ctr_reg, ctr_next;

    // The item under way.
    logic [ADDR_W-1:0] block_reg;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [IW-1:0]     base_reg, base_next;
    logic [CW-1:0]     ways_reg, ways_next;
    logic [IW-1:0]     set_idx;

    // Scan results.
    logic [CW-1:0]    nvalid_reg, nvalid_next;
    logic             hit_reg, hit_next;
    logic [IW-1:0]    hitw_reg, hitw_next;
    logic [IW-1:0]    hitr_reg, hitr_next;
    logic             free_reg, free_next;
    logic [IW-1:0]    freew_reg, freew_next;
    logic [IW-1:0]    vicw_reg, vicw_next;
    logic [IW-1:0]    vicr_reg, vicr_next;
    logic [TAG_W-1:0] victag_reg, victag_next;

    // Tag store: valid bit, order rank and tag per line.
    logic             valid_mem [MAX_LINES];
    logic [IW-1:0]    rank_mem  [MAX_LINES];
    logic [TAG_W-1:0] tag_mem   [MAX_LINES];

    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic             rd_valid_q;
    logic [IW-1:0]    rd_rank_q;
    logic [TAG_W-1:0] rd_tag_q;
    logic             rd_pend_reg, rd_pend_next;
    logic [IW-1:0]    rd_w_reg, rd_w_next;
    logic             last_data;

    logic             we;
    logic [IW-1:0]    wr_addr;
    logic             wr_valid;
    logic [IW-1:0]    wr_rank;
    logic [TAG_W-1:0] wr_tag;

    logic [IW-1:0]    key_w;
    logic [IW-1:0]    key_r;

    // Results and counters.
    logic             done_reg, done_next;
    logic             miss_reg, miss_next;
    logic             evicted_reg, evicted_next;
    logic [TAG_W-1:0] vtag_out_reg, vtag_out_next;
    logic [CNT_W-1:0] acc_total_reg, acc_total_next;
    logic [CNT_W-1:0] miss_total_reg, miss_total_next;

    logic cfg_we;

    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx_t'(paddr[3:2]))
            REG_ASSOC:  prdata = DATA_W'(assoc_reg);
            REG_POLICY: prdata = DATA_W'(policy_reg);
            REG_OFFSET: prdata = DATA_W'(offset_reg);
            REG_LINES:  prdata = DATA_W'(lines_reg);
        endcase
    end

    // A line count beyond the store is clamped to the store size. Direct
    // mapped uses one way, the set associative mode SET_WAYS ways, and the
    // fully associative mode (and the spare code) every line in one set. The
    // way count never exceeds the line count.
    always_comb
    begin
        if (32'(lines_reg) > IW)
        begin
            lcl_eff = LW'(IW);
        end
        else
        begin
            lcl_eff = LW'(lines_reg);
        end

        unique case (assoc_reg)
            ASSOC_DIRECT:
            begin
                ways_log2 = '0;
            end
            ASSOC_SET:
            begin
                if (WL > 32'(lcl_eff))
                begin
                    ways_log2 = lcl_eff;
                end
                else
                begin
                    ways_log2 = LW'(WL);
                end
            end
            default:
            begin
                ways_log2 = lcl_eff;
            end
        endcase

        sets_log2 = lcl_eff - ways_log2;
        lru       = (assoc_reg != ASSOC_DIRECT) && (policy_reg == POLICY_LRU);
    end

    // Set index and tag come from the block address; set s owns the lines
    // s*ways onwards, so a line index is the base with the way in its low bits.
    assign set_idx   = block_reg[IW-1:0] & ~({IW{1'b1}} << sets_log2);
    assign last_data = rd_pend_reg && ({1'b0, rd_w_reg} == ways_reg - CW'(1));

    // On an LRU hit the hit line is the reference, on an eviction the victim.
    assign key_w = hit_reg ? hitw_reg : vicw_reg;
    assign key_r = hit_reg ? hitr_reg : vicr_reg;

    always_comb
    begin
        state_next      = state_reg;
        ctr_next        = ctr_reg;
        tag_next        = tag_reg;
        base_next       = base_reg;
        ways_next       = ways_reg;
        nvalid_next     = nvalid_reg;
        hit_next        = hit_reg;
        hitw_next       = hitw_reg;
        hitr_next       = hitr_reg;
        free_next       = free_reg;
        freew_next      = freew_reg;
        vicw_next       = vicw_reg;
        vicr_next       = vicr_reg;
        victag_next     = victag_reg;
        done_next       = 1'b0;
        miss_next       = miss_reg;
        evicted_next    = evicted_reg;
        vtag_out_next   = vtag_out_reg;
        acc_total_next  = acc_total_reg;
        miss_total_next = miss_total_reg;

        rd_en        = 1'b0;
        rd_addr      = base_reg | ctr_reg[IW-1:0];
        rd_pend_next = 1'b0;
        rd_w_next    = ctr_reg[IW-1:0];

        we       = 1'b0;
        wr_addr  = base_reg | rd_w_reg;
        wr_valid = rd_valid_q;
        wr_rank  = rd_rank_q;
        wr_tag   = rd_tag_q;

        unique case (state_reg)
            S_CLEAR:
            begin
                we       = 1'b1;
                wr_addr  = ctr_reg[IW-1:0];
                wr_valid = 1'b0;
                ctr_next = ctr_reg + CW'(1);
                if (ctr_reg[IW-1:0] == {IW{1'b1}})
                begin
                    ctr_next   = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SETUP;
                end
            end

            S_SETUP:
            begin
                tag_next    = block_reg >> sets_log2;
                base_next   = set_idx << ways_log2;
                ways_next   = CW'(1) << ways_log2;
                ctr_next    = '0;
                nvalid_next = '0;
                hit_next    = 1'b0;
                free_next   = 1'b0;
                state_next  = S_SCAN;
            end

            S_SCAN:
            begin
                if (ctr_reg < ways_reg)
                begin
                    rd_en        = 1'b1;
                    rd_pend_next = 1'b1;
                    ctr_next     = ctr_reg + CW'(1);
                end
                if (rd_pend_reg)
                begin
                    if (rd_valid_q)
                    begin
                        nvalid_next = nvalid_reg + CW'(1);
                        if (!hit_reg && rd_tag_q == tag_reg)
                        begin
                            hit_next  = 1'b1;
                            hitw_next = rd_w_reg;
                            hitr_next = rd_rank_q;
                        end
                    end
                    else if (!free_reg)
                    begin
                        free_next  = 1'b1;
                        freew_next = rd_w_reg;
                    end
                    // Oldest line: lowest rank, lowest way on a tie.
                    if (rd_w_reg == '0 || rd_rank_q < vicr_reg)
                    begin
                        vicw_next   = rd_w_reg;
                        vicr_next   = rd_rank_q;
                        victag_next = rd_tag_q;
                    end
                    if (last_data)
                    begin
                        ctr_next = '0;
                        if (hit_next)
                        begin
                            state_next = lru ? S_UPDATE : S_FINISH;
                        end
                        else if (free_next)
                        begin
                            state_next = S_FILL;
                        end
                        else
                        begin
                            state_next = S_UPDATE;
                        end
                    end
                end
            end

            S_UPDATE:
            begin
                if (ctr_reg < ways_reg)
                begin
                    rd_en        = 1'b1;
                    rd_pend_next = 1'b1;
                    ctr_next     = ctr_reg + CW'(1);
                end
                if (rd_pend_reg)
                begin
                    we = 1'b1;
                    if (rd_w_reg == key_w)
                    begin
                        if (hit_reg)
                        begin
                            wr_rank = IW'(nvalid_reg - CW'(1));
                        end
                        else
                        begin
                            wr_tag  = tag_reg;
                            wr_rank = IW'(ways_reg - CW'(1));
                        end
                    end
                    else if (rd_valid_q && rd_rank_q > key_r)
                    begin
                        wr_rank = rd_rank_q - IW'(1);
                    end
                    if (last_data)
                    begin
                        ctr_next   = '0;
                        state_next = S_FINISH;
                    end
                end
            end

            S_FILL:
            begin
                we         = 1'b1;
                wr_addr    = base_reg | freew_reg;
                wr_valid   = 1'b1;
                wr_tag     = tag_reg;
                wr_rank    = IW'(nvalid_reg);
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                done_next     = 1'b1;
                miss_next     = !hit_reg;
                evicted_next  = !hit_reg && !free_reg;
                vtag_out_next = (!hit_reg && !free_reg) ? victag_reg : '0;
                if (acc_total_reg != {CNT_W{1'b1}})
                begin
                    acc_total_next = acc_total_reg + CNT_W'(1);
                end
                if (!hit_reg && miss_total_reg != {CNT_W{1'b1}})
                begin
                    miss_total_next = miss_total_reg + CNT_W'(1);
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            ctr_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            done_reg       <= 1'b0;
            acc_total_reg  <= '0;
            miss_total_reg <= '0;
            assoc_reg      <= ASSOC_RST;
            policy_reg     <= POLICY_RST;
            offset_reg     <= OFFS_RST;
            lines_reg      <= LCL_RST;
        end
        else
        begin
            state_reg      <= state_next;
            ctr_reg        <= ctr_next;
            rd_pend_reg    <= rd_pend_next;
            done_reg       <= done_next;
            acc_total_reg  <= acc_total_next;
            miss_total_reg <= miss_total_next;
            if (cfg_we)
            begin
                unique case (reg_idx_t'(paddr[3:2]))
                    REG_ASSOC:  assoc_reg  <= pwdata[ASSOC_W-1:0];
                    REG_POLICY: policy_reg <= pwdata[0];
                    REG_OFFSET: offset_reg <= pwdata[OFFS_W-1:0];
                    REG_LINES:  lines_reg  <= pwdata[LCL_W-1:0];
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            block_reg <= word_address >> offset_reg;
        end
        tag_reg      <= tag_next;
        base_reg     <= base_next;
        ways_reg     <= ways_next;
        nvalid_reg   <= nvalid_next;
        hit_reg      <= hit_next;
        hitw_reg     <= hitw_next;
        hitr_reg     <= hitr_next;
        free_reg     <= free_next;
        freew_reg    <= freew_next;
        vicw_reg     <= vicw_next;
        vicr_reg     <= vicr_next;
        victag_reg   <= victag_next;
        rd_w_reg     <= rd_w_next;
        miss_reg     <= miss_next;
        evicted_reg  <= evicted_next;
        vtag_out_reg <= vtag_out_next;
    end

    // Tag store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            valid_mem[wr_addr] <= wr_valid;
            rank_mem[wr_addr]  <= wr_rank;
            tag_mem[wr_addr]   <= wr_tag;
        end
        if (rd_en)
        begin
            rd_valid_q <= valid_mem[rd_addr];
            rd_rank_q  <= rank_mem[rd_addr];
            rd_tag_q   <= tag_mem[rd_addr];
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign miss         = miss_reg;
    assign evicted      = evicted_reg;
    assign victim_tag   = vtag_out_reg;
    assign access_count = acc_total_reg;
    assign miss_count   = miss_total_reg;

endmodule

FILE: rtl/ctrm_checker.sv
// ----------------------------------------------------------------------------
// ctrm_checker
// Port-level checks on the item and result channels of the cache tag store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cache_tag_replacement_model_assert.svh"

module ctrm_checker
    import ctrm_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input logic             miss,
    input logic [CNT_W-1:0] access_count,
    input logic [CNT_W-1:0] miss_count
);

    // A result is shown once the block has returned to idle.
    `CTRM_ASSERT_SAME(a_done_idle, done, !busy, "result shown while busy")

    // Each item passes through setup, scan and finish, so results never come back to back.
    `CTRM_ASSERT_NEXT(a_done_single, done, !done, "result strobe held two cycles")

    // With no item taken the counters do not move.
    `CTRM_ASSERT_NEXT(a_count_hold, !busy && !start,
        $stable(access_count) && $stable(miss_count), "counter moved while idle")

    // A hit leaves the miss counter as it was.
    `CTRM_ASSERT_SAME(a_hit_count, done && !miss, miss_count == $past(miss_count),
        "miss counter advanced on a hit")

endmodule

bind cache_tag_replacement_model ctrm_checker u_ctrm_checker (.*);

FILE: tb/cache_tag_replacement_model_tb.sv
// ----------------------------------------------------------------------------
// cache_tag_replacement_model_tb
// Self-checking bench for the cache tag store: a short walk through a list of
// hand-picked accesses and register writes, followed by random phases under
// random organizations, each checked result by result against a behavioural
// model of the tag store and its replacement order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cache_tag_replacement_model_tb;

    import ctrm_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 9;
    localparam int MAX_LINES      = 1024;
    localparam int SET_WAYS       = 4;
    localparam int RANDOM_PHASES  = 14;
    localparam int PHASE_ITEMS    = 92;
    localparam int POOL_DEPTH     = 40;
    localparam int NOISE_PCT      = 15;
    localparam int TAIL_CYCLES    = 64;
    localparam int REPORT_LIMIT   = 10;
    localparam int TIMEOUT_CYCLES = 1_500_000;

    // The package names three organizations; the fourth encoding is legal and
    // must behave as fully associative.
    localparam logic [ASSOC_W-1:0] ASSOC_FULL_ALIAS = 2'd3;

    // One result of the block, in the order of its ports.
    typedef struct packed {
        logic             miss;
        logic             evicted;
        logic [TAG_W-1:0] victim_tag;
        logic [CNT_W-1:0] access_count;
        logic [CNT_W-1:0] miss_count;
    } access_outcome_t;

    // One line of the directed list: either a register write or an access,
    // the latter optionally with its outcome written out by hand.
    typedef struct {
        bit                is_write;
        reg_idx_t          reg_sel;
        logic [DATA_W-1:0] reg_value;
        logic [ADDR_W-1:0] address;
        bit                known;
        access_outcome_t   known_outcome;
    } stim_row_t;

    // ------------------------------------------------------------------------
    // Signals. Every input carries a defined value from time zero.
    // ------------------------------------------------------------------------
    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [PADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0]  pwdata       = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               start        = 1'b0;
    logic               busy;
    logic [ADDR_W-1:0]  word_address = '0;
    logic               done;
    logic               miss;
    logic               evicted;
    logic [TAG_W-1:0]   victim_tag;
    logic [CNT_W-1:0]   access_count;
    logic [CNT_W-1:0]   miss_count;

    cache_tag_replacement_model #(
        .MAX_LINES (MAX_LINES),
        .SET_WAYS  (SET_WAYS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .word_address (word_address),
        .done         (done),
        .miss         (miss),
        .evicted      (evicted),
        .victim_tag   (victim_tag),
        .access_count (access_count),
        .miss_count   (miss_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Behavioural copy of the tag store. The register mirror follows every
    // write made through the configuration port, and the store itself is
    // never cleared between phases, exactly as in the block.
    // ------------------------------------------------------------------------
    logic [ASSOC_W-1:0] shadow_assoc      = ASSOC_RST;
    logic               shadow_policy     = POLICY_RST;
    logic [OFFS_W-1:0]  shadow_offset     = OFFS_RST;
    logic [LCL_W-1:0]   shadow_lines_log2 = LCL_RST;

    bit                 line_valid [MAX_LINES];
    logic [TAG_W-1:0]   line_tag   [MAX_LINES];
    int unsigned        line_age   [MAX_LINES];
    logic [CNT_W-1:0]   access_tally = '0;
    logic [CNT_W-1:0]   miss_tally   = '0;

    // Outcomes predicted for accepted items, oldest first.
    access_outcome_t    pending_outcomes [$];
    stim_row_t          directed_rows [$];
    int unsigned        fault_count = 0;

    // Working set for the random phases: a handful of blocks crowded onto a
    // few sets, so that hits, fills and evictions all occur often.
    logic [63:0]        pool_block [POOL_DEPTH];
    int unsigned        pool_size;

    initial begin
        for (int i = 0; i < MAX_LINES; i++)
        begin
            line_valid[i] = 1'b0;
            line_tag[i]   = '0;
            line_age[i]   = 0;
        end
    end

    function automatic logic [CNT_W-1:0] bump_saturating(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Lines in use, ways per set and number of sets under the current
    // registers. Oversized line counts are halved down to the store size, and
    // the way count never exceeds the line count.
    function automatic void derive_geometry(output int unsigned lines,
                                            output int unsigned ways,
                                            output int unsigned sets);
        lines = 32'd1 << shadow_lines_log2;
        while (lines > MAX_LINES)
        begin
            lines = lines >> 1;
        end
        if (shadow_assoc == ASSOC_DIRECT)
        begin
            ways = 1;
        end
        else if (shadow_assoc == ASSOC_SET)
        begin
            ways = SET_WAYS;
        end
        else
        begin
            ways = lines;
        end
        if (ways > lines)
        begin
            ways = lines;
        end
        sets = lines / ways;
    endfunction

    // Runs one access against the copied store and returns what the block
    // should report for it. Age 0 is the oldest line of a set.
    function automatic access_outcome_t predict_access_outcome(input logic [ADDR_W-1:0] addr);
        access_outcome_t   outcome;
        logic [ADDR_W-1:0] block;
        logic [TAG_W-1:0]  tag;
        int unsigned       lines, ways, sets, set_idx, base, idx, filled;
        int unsigned       hit_line, victim, pivot_age;
        bit                hit, lru;
        outcome   = '0;
        block     = addr >> shadow_offset;
        derive_geometry(lines, ways, sets);
        lru       = (shadow_assoc != ASSOC_DIRECT) && (shadow_policy == POLICY_LRU);
        set_idx   = block % sets;
        tag       = TAG_W'(block / sets);
        base      = set_idx * ways;
        filled    = 0;
        hit       = 1'b0;
        hit_line  = 0;

        access_tally = bump_saturating(access_tally);

        // The first valid way with a matching tag wins, even when a change of
        // mapping has left duplicates behind.
        for (int w = 0; w < ways; w++)
        begin
            idx = base + w;
            if (line_valid[idx])
            begin
                filled++;
                if (!hit && line_tag[idx] == tag)
                begin
                    hit      = 1'b1;
                    hit_line = idx;
                end
            end
        end

        if (hit)
        begin
            if (lru)
            begin
                pivot_age = line_age[hit_line];
                for (int w = 0; w < ways; w++)
                begin
                    idx = base + w;
                    if (line_valid[idx] && idx != hit_line && line_age[idx] > pivot_age)
                    begin
                        line_age[idx]--;
                    end
                end
                line_age[hit_line] = filled - 1;
            end
        end
        else
        begin
            miss_tally = bump_saturating(miss_tally);
            if (filled < ways)
            begin
                idx = base;
                while (line_valid[idx])
                begin
                    idx++;
                end
                line_valid[idx] = 1'b1;
                line_tag[idx]   = tag;
                line_age[idx]   = filled;
            end
            else
            begin
                // Oldest line goes; on equal ages the lowest way is taken.
                victim = base;
                for (int w = 1; w < ways; w++)
                begin
                    if (line_age[base + w] < line_age[victim])
                    begin
                        victim = base + w;
                    end
                end
                pivot_age          = line_age[victim];
                outcome.evicted    = 1'b1;
                outcome.victim_tag = line_tag[victim];
                for (int w = 0; w < ways; w++)
                begin
                    idx = base + w;
                    if (idx != victim && line_age[idx] > pivot_age)
                    begin
                        line_age[idx]--;
                    end
                end
                line_tag[victim] = tag;
                line_age[victim] = ways - 1;
            end
        end

        outcome.miss         = !hit;
        outcome.access_count = access_tally;
        outcome.miss_count   = miss_tally;
        return outcome;
    endfunction

    // ------------------------------------------------------------------------
    // Fault reporting: the first few are described, the rest only counted.
    // ------------------------------------------------------------------------
    task automatic note_fault(input string text);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
        begin
            $display("[%0t] %s", $realtime, text);
        end
    endtask

    task automatic compare_field(input string name, input logic [CNT_W-1:0] want,
                                 input logic [CNT_W-1:0] got);
        if (got !== want)
        begin
            note_fault($sformatf("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got));
        end
    endtask

    // Results are taken at the edge that closes their one-cycle window; the
    // values seen here are those from before the edge.
    always @(posedge clk)
    begin : result_monitor
        access_outcome_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_outcomes.size() == 0)
            begin
                note_fault("result delivered while no item was outstanding");
            end
            else
            begin
                want = pending_outcomes[0];
                pending_outcomes.delete(0);
                compare_field("miss", CNT_W'(want.miss), CNT_W'(miss));
                compare_field("evicted", CNT_W'(want.evicted), CNT_W'(evicted));
                compare_field("victim_tag", CNT_W'(want.victim_tag), CNT_W'(victim_tag));
                compare_field("access_count", want.access_count, access_count);
                compare_field("miss_count", want.miss_count, miss_count);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Draws an idle burst with the given chance, else none.
    function automatic int unsigned draw_gap(input int unsigned idle_pct);
        return ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    endfunction

    // Offers one item and waits for the block to take it. start is left high
    // on return, so back-to-back items need no new edge on it; a gap lowers it
    // and raises it again in a later step.
    task automatic issue_access(input logic [ADDR_W-1:0] addr, input int unsigned gap,
                                input bit known, input access_outcome_t known_outcome);
        access_outcome_t predicted;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        word_address <= addr;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        // The model is always advanced, even where the outcome is written
        // out by hand, so that the store stays in step.
        predicted = predict_access_outcome(addr);
        pending_outcomes = {pending_outcomes, (known ? known_outcome : predicted)};
    endtask

    // Stops offering items and waits for every outstanding result. Each item
    // produces a result, so once the queue is empty the block is idle.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    // Setup phase, then access phase; the write lands on the edge where the
    // access phase meets pready.
    task automatic write_register(input reg_idx_t sel, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        unique case (sel)
            REG_ASSOC:  shadow_assoc      = value[ASSOC_W-1:0];
            REG_POLICY: shadow_policy     = value[0];
            REG_OFFSET: shadow_offset     = value[OFFS_W-1:0];
            REG_LINES:  shadow_lines_log2 = value[LCL_W-1:0];
        endcase
    endtask

    // An empty row: an access to address zero with no outcome written out.
    function automatic stim_row_t blank_row();
        stim_row_t row;
        row.is_write      = 1'b0;
        row.reg_sel       = REG_ASSOC;
        row.reg_value     = '0;
        row.address       = '0;
        row.known         = 1'b0;
        row.known_outcome = '0;
        return row;
    endfunction

    task automatic add_write(input reg_idx_t sel, input logic [DATA_W-1:0] value);
        stim_row_t row;
        row           = blank_row();
        row.is_write  = 1'b1;
        row.reg_sel   = sel;
        row.reg_value = value;
        directed_rows = {directed_rows, row};
    endtask

    task automatic add_access(input logic [ADDR_W-1:0] addr);
        stim_row_t row;
        row           = blank_row();
        row.address   = addr;
        directed_rows = {directed_rows, row};
    endtask

    task automatic add_known(input logic [ADDR_W-1:0] addr, input logic m, input logic ev,
                             input logic [TAG_W-1:0] vtag, input int unsigned acc,
                             input int unsigned mis);
        stim_row_t row;
        row                            = blank_row();
        row.address                    = addr;
        row.known                      = 1'b1;
        row.known_outcome.miss         = m;
        row.known_outcome.evicted      = ev;
        row.known_outcome.victim_tag   = vtag;
        row.known_outcome.access_count = acc;
        row.known_outcome.miss_count   = mis;
        directed_rows                  = {directed_rows, row};
    endtask

    // Fills the working set for one random phase: tags of varied magnitude
    // on up to three hot sets; a phase uses two to 2*ways+2 of them, at most POOL_DEPTH.
    task automatic build_pool();
        int unsigned lines, ways, sets;
        logic [63:0] hot_set [3];
        logic [63:0] tag;
        derive_geometry(lines, ways, sets);
        for (int k = 0; k < 3; k++)
        begin
            hot_set[k] = 64'($urandom_range(sets - 1));
        end
        pool_size = $urandom_range(2, (2 * ways + 2 < POOL_DEPTH) ? 2 * ways + 2 : POOL_DEPTH);
        for (int k = 0; k < POOL_DEPTH; k++)
        begin
            tag           = 64'($urandom) >> $urandom_range(0, 31);
            pool_block[k] = tag * sets + hot_set[$urandom_range(2)];
        end
    endtask

    // Mostly a block from the working set with random bits below the block
    // boundary; now and then an address drawn over the full range.
    function automatic logic [ADDR_W-1:0] draw_address();
        logic [63:0] low_mask;
        logic [63:0] full;
        if ($urandom_range(99) < NOISE_PCT)
        begin
            return ADDR_W'($urandom);
        end
        low_mask = (64'd1 << shadow_offset) - 1;
        full     = (pool_block[$urandom_range(pool_size - 1)] << shadow_offset)
                   | ({$urandom, $urandom} & low_mask);
        return full[ADDR_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        access_outcome_t   none;
        logic [DATA_W-1:0] pick_offset;
        logic [DATA_W-1:0] pick_lines;
        logic [DATA_W-1:0] pick_assoc;
        int unsigned       idle_pct;
        none = '0;

        // Reset defaults: direct mapped, four words a block, 1024 lines.
        // The first few outcomes follow directly from an empty store.
        add_known(31'h0000_0000, 1'b1, 1'b0, 31'h0, 1, 1);
        add_known(31'h0000_0003, 1'b0, 1'b0, 31'h0, 2, 1);
        add_known(31'h0000_1000, 1'b1, 1'b1, 31'h0, 3, 2);
        add_known(31'h7FFF_FFFF, 1'b1, 1'b0, 31'h0, 4, 3);
        add_known(31'h7FFF_FFFC, 1'b0, 1'b0, 31'h0, 5, 3);
        add_known(31'h0000_0000, 1'b1, 1'b1, 31'h1, 6, 4);

        // A single four-way set under LRU, reusing what the direct-mapped
        // phase left in the store, with two hits that reorder the set and two
        // evictions.
        add_write(REG_ASSOC, DATA_W'(ASSOC_SET));
        add_write(REG_POLICY, DATA_W'(POLICY_LRU));
        add_write(REG_OFFSET, 32'd0);
        add_write(REG_LINES, 32'd2);
        add_access(31'd1);
        add_access(31'd2);
        add_access(31'd3);
        add_access(31'd0);
        add_access(31'd4);
        add_access(31'd2);
        add_access(31'd5);

        // The spare organization code, a single line and the widest shift:
        // every address falls into block zero. Upper data bits are ignored.
        add_write(REG_ASSOC, DATA_W'(ASSOC_FULL_ALIAS));
        add_write(REG_POLICY, DATA_W'(POLICY_FIFO));
        add_write(REG_OFFSET, 32'hFFFF_FFFF);
        add_write(REG_LINES, 32'd0);
        add_access(31'h7FFF_FFFF);
        add_access(31'h0000_0000);

        // Line count beyond the store, cut back to all 1024 lines in one set.
        add_write(REG_ASSOC, DATA_W'(ASSOC_FULL));
        add_write(REG_OFFSET, 32'd16);
        add_write(REG_LINES, 32'd15);
        add_access(31'h7FFF_0000);
        add_access(31'h0001_0000);

        // Two lines only: the four-way organization is cut down to two ways.
        add_write(REG_ASSOC, DATA_W'(ASSOC_SET));
        add_write(REG_POLICY, DATA_W'(POLICY_LRU));
        add_write(REG_OFFSET, 32'd0);
        add_write(REG_LINES, 32'd1);
        add_access(31'd0);
        add_access(31'd1);
        add_access(31'd2);
        add_access(31'd0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // The block sweeps its valid bits after reset; the first item simply
        // waits on busy.
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].is_write)
            begin
                drain_results();
                write_register(directed_rows[r].reg_sel, directed_rows[r].reg_value);
            end
            else
            begin
                issue_access(directed_rows[r].address, draw_gap(30),
                             directed_rows[r].known, directed_rows[r].known_outcome);
            end
        end

        // Random phases. Each picks a fresh organization but keeps the store,
        // so that stale lines are read under the new mapping. Fully
        // associative phases stay small, as their lookup time grows with the
        // line count. The last two phases run without gaps.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_results();
            pick_assoc = $urandom_range(0, 3);
            case ($urandom_range(0, 3)) inside
                [0:1]:   pick_offset = $urandom_range(0, 4);
                2:       pick_offset = $urandom_range(0, 31);
                default: pick_offset = ($urandom_range(1) != 0) ? 32'd31 : 32'd16;
            endcase
            if (pick_assoc >= ASSOC_FULL)
            begin
                pick_lines = $urandom_range(0, 6);
            end
            else if ($urandom_range(3) == 0)
            begin
                pick_lines = $urandom_range(0, 15);
            end
            else
            begin
                pick_lines = $urandom_range(2, 6);
            end
            write_register(REG_ASSOC, pick_assoc);
            write_register(REG_POLICY, $urandom_range(0, 1));
            write_register(REG_OFFSET, pick_offset);
            write_register(REG_LINES, pick_lines);
            build_pool();

            if (phase >= RANDOM_PHASES - 2)
            begin
                idle_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 25;
                    default: idle_pct = 50;
                endcase
            end

            repeat (PHASE_ITEMS)
            begin
                issue_access(draw_address(), draw_gap(idle_pct), 1'b0, none);
            end
        end

        // Everything outstanding must arrive, and nothing more may follow.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Safety net against a block that stops answering.
    initial begin : watchdog
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
